// ===== design/box_blur_5x5_clipped_core_defines.svh =====
// Assertion helpers for the top-level design file.
`ifndef BOX_BLUR_5X5_CLIPPED_CORE_DEFINES_SVH
`define BOX_BLUR_5X5_CLIPPED_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bbc check failed");

// Next-cycle implication.
`define BBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bbc check failed");

`endif

// ===== design/bbc_pkg.sv =====
`timescale 1ns / 1ps
package bbc_pkg;

  // Field widths
  localparam int CH_W     = 8;
  localparam int PIX_W    = 3 * CH_W;
  localparam int CFG_WW   = 11;
  localparam int CFG_HW   = 16;
  localparam int CFG_DW   = 16;
  localparam int ROW_W    = 16;

  // Sized for the largest window (radius 2): one row of 5 pixels, 25 in all
  localparam int LSUM_W   = 11;
  localparam int LCNT_W   = 3;
  localparam int SUM_W    = 13;
  localparam int CNT_W    = 5;

  // Register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Item kinds
  localparam logic MODE_PIXEL = 1'b0;

  // Per-cycle lane control
  typedef struct packed {
    logic clr;
    logic rd;
    logic col_ok;
  } lane_ctrl_t;

  // One lane's partial result: channel sums (0 red, 1 green, 2 blue) and pixel count
  typedef struct packed {
    logic [2:0][LSUM_W-1:0] ch;
    logic [LCNT_W-1:0]      cnt;
  } lane_sum_t;

endpackage

// ===== design/bbc_ram.sv =====
`timescale 1ns / 1ps
module bbc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 7168
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/bbc_lane.sv =====
`timescale 1ns / 1ps
module bbc_lane #(
  parameter int MAX_WIDTH = 1024,
  parameter int RING      = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bbc_pkg::lane_ctrl_t                 ctrl,
  input  logic                                row_ok,
  input  logic [$clog2(RING)-1:0]             ring,
  input  logic [$clog2(MAX_WIDTH)-1:0]        col,
  input  logic                                wr_en,
  input  logic [$clog2(RING*MAX_WIDTH)-1:0]   wr_addr,
  input  logic [bbc_pkg::PIX_W-1:0]           wr_data,
  output bbc_pkg::lane_sum_t                  sum
);

  localparam int AW = $clog2(RING * MAX_WIDTH);

  logic [AW-1:0]                 rd_addr;
  logic [bbc_pkg::PIX_W-1:0]     rd_data;
  logic                          rd_ok_r;
  bbc_pkg::lane_sum_t            acc_r;

  // Row of the ring, column within the row
  assign rd_addr = AW'(ring) * AW'(MAX_WIDTH) + AW'(col);

  // Full copy of the ring rows; every lane sees every write
  bbc_ram #(
    .WIDTH (bbc_pkg::PIX_W),
    .DEPTH (RING * MAX_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctrl.rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Accumulate this lane's row of the window, one column per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r <= 1'b0;
      acc_r   <= '0;
    end else begin
      rd_ok_r <= ctrl.rd & ctrl.col_ok & row_ok;
      if (ctrl.clr) begin
        acc_r <= '0;
      end else if (rd_ok_r) begin
        for (int c = 0; c < 3; c++) begin
          acc_r.ch[c] <= acc_r.ch[c] + bbc_pkg::LSUM_W'(rd_data[(2-c)*bbc_pkg::CH_W +:
                                                             bbc_pkg::CH_W]);
        end
        acc_r.cnt <= acc_r.cnt + 1'b1;
      end
    end
  end

  assign sum = acc_r;

endmodule

// ===== design/bbc_merge.sv =====
`timescale 1ns / 1ps
module bbc_merge #(
  parameter int LANES = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  bbc_pkg::lane_sum_t         lane_sum [LANES],
  output logic                       done,
  output logic [2:0][bbc_pkg::CH_W-1:0] mean
);

  localparam int SW = bbc_pkg::SUM_W;
  localparam int NW = bbc_pkg::CNT_W;

  logic [2:0][SW-1:0]   tot;
  logic [NW-1:0]        cnt;
  logic                 busy_r;
  logic                 done_r;
  logic [3:0]           step_r;
  logic [NW-1:0]        n_r;
  logic [2:0][NW-1:0]   rem_r;
  logic [2:0][SW-1:0]   dq_r;
  logic [2:0][NW:0]     trial;
  logic [2:0]           ge;

  // Merge the lane partials
  always_comb begin
    tot = '0;
    cnt = '0;
    for (int l = 0; l < LANES; l++) begin
      for (int c = 0; c < 3; c++) begin
        tot[c] = tot[c] + SW'(lane_sum[l].ch[c]);
      end
      cnt = cnt + NW'(lane_sum[l].cnt);
    end
  end

  // One restoring division step per cycle, three channels side by side
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem_r[c], dq_r[c][SW-1]};
      ge[c]    = trial[c] >= {1'b0, n_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
      n_r    <= '0;
      rem_r  <= '0;
      dq_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        n_r    <= cnt;
        rem_r  <= '0;
        dq_r   <= tot;
      end else if (busy_r) begin
        for (int c = 0; c < 3; c++) begin
          rem_r[c] <= ge[c] ? NW'(trial[c] - {1'b0, n_r}) : NW'(trial[c]);
          dq_r[c]  <= {dq_r[c][SW-2:0], ge[c]};
        end
        step_r <= step_r + 1'b1;
        if (step_r == 4'(SW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mean[c] = dq_r[c][bbc_pkg::CH_W-1:0];
    end
  end

endmodule

// ===== design/box_blur_5x5_clipped_core.sv =====
// Streaming box blur: RGB pixels of one frame enter in raster order; each result is the
// truncated per-channel mean over the (2*RADIUS+1)^2 window clipped to the image. Results
// trail the input by RADIUS*width+RADIUS pixels; after the last pixel, flush items
// (in_mode=1) release the rest, and out_frame_done marks the frame's last result. A pixel
// that gives no result leaves the input ready. One that gives a result goes through
// 2*RADIUS+1 column reads, in which 2*RADIUS+1 row lanes each read one pixel from
// their own copy of the (3*RADIUS+1)-row pixel store, a merge of the lane sums, and a
// 13-step divider shared by the three channels. The input is taken again as soon as a
// result is parked in the output register. Writing a register aborts the current frame.
`timescale 1ns / 1ps
`include "box_blur_5x5_clipped_core_defines.svh"
module box_blur_5x5_clipped_core #(
  parameter int MAX_WIDTH = 1024,
  parameter int RADIUS    = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [bbc_pkg::CFG_DW-1:0]  cfg_wdata,
  // pixel input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic [bbc_pkg::CH_W-1:0]    in_red_in,
  input  logic [bbc_pkg::CH_W-1:0]    in_green_in,
  input  logic [bbc_pkg::CH_W-1:0]    in_blue_in,
  // results
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bbc_pkg::CH_W-1:0]    out_red_out,
  output logic [bbc_pkg::CH_W-1:0]    out_green_out,
  output logic [bbc_pkg::CH_W-1:0]    out_blue_out,
  output logic                        out_frame_done
);

  localparam int LANES = 2 * RADIUS + 1;
  localparam int RING  = 3 * RADIUS + 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RGW   = $clog2(RING);
  localparam int RW    = WW + bbc_pkg::ROW_W;
  localparam int KW    = $clog2(LANES);
  localparam int AW    = $clog2(RING * MAX_WIDTH);
  localparam int HW    = bbc_pkg::ROW_W;
  localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_SUM,
    S_DIV,
    S_OUT
  } state_t;

  state_t               state_r, state_nxt;
  logic [WW-1:0]        w_eff_r, w_eff_nxt;
  logic [HW-1:0]        h_eff_r, h_eff_nxt;
  logic [CW-1:0]        in_col_r, in_col_nxt;
  logic [HW-1:0]        in_row_r, in_row_nxt;
  logic [RGW-1:0]       in_ring_r, in_ring_nxt;
  logic [CW-1:0]        out_col_r, out_col_nxt;
  logic [HW-1:0]        out_row_r, out_row_nxt;
  logic [RGW-1:0]       out_ring_r, out_ring_nxt;
  logic [RW-1:0]        rcv_r, rcv_nxt;
  logic [CW-1:0]        wrk_col_r, wrk_col_nxt;
  logic [HW-1:0]        wrk_row_r, wrk_row_nxt;
  logic [RGW-1:0]       wrk_ring_r, wrk_ring_nxt;
  logic                 wrk_last_r, wrk_last_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [2:0][bbc_pkg::CH_W-1:0] out_mean_r, out_mean_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 in_fire;
  logic                 is_pixel;
  logic                 in_full;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [bbc_pkg::PIX_W-1:0] wr_data;
  logic [RW-1:0]        rcv_inc;
  logic [RW-1:0]        lag;
  logic                 start;
  logic                 last;
  logic                 in_wrap;
  logic                 out_wrap;
  logic [WW:0]          col_k;
  logic                 col_ok;
  logic [CW-1:0]        col_x;
  logic [WW-1:0]        cfg_w_clip;
  logic [bbc_pkg::CFG_WW-1:0] cfg_w;
  logic [HW-1:0]        cfg_h;
  logic                 mrg_done;
  logic [2:0][bbc_pkg::CH_W-1:0] mrg_mean;
  bbc_pkg::lane_ctrl_t  lane_ctrl;
  bbc_pkg::lane_sum_t   lane_sum [LANES];

  // Handshake and frame bookkeeping
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign is_pixel = (in_mode == bbc_pkg::MODE_PIXEL);
  assign in_full  = (in_row_r >= h_eff_r);
  assign wr_en    = in_fire && is_pixel && !in_full;
  assign wr_addr  = AW'(in_ring_r) * AW'(MAX_WIDTH) + AW'(in_col_r);
  assign wr_data  = {in_red_in, in_green_in, in_blue_in};
  assign rcv_inc  = rcv_r + 1'b1;
  assign lag      = RW'(w_eff_r) * RW'(RADIUS) + RW'(RADIUS);
  assign start    = in_fire && ((is_pixel && !in_full && (rcv_inc > lag)) ||
                                (!is_pixel && in_full));
  assign last     = (out_row_r == h_eff_r - 1'b1) && (WW'(out_col_r) == w_eff_r - 1'b1);
  assign in_wrap  = (WW'(in_col_r) + 1'b1 >= w_eff_r);
  assign out_wrap = (WW'(out_col_r) + 1'b1 >= w_eff_r);

  // Configuration values as used: width clipped to 1..MAX_WIDTH, height at least 1
  assign cfg_w      = cfg_wdata[bbc_pkg::CFG_WW-1:0];
  assign cfg_h      = cfg_wdata[bbc_pkg::CFG_HW-1:0];
  assign cfg_w_clip = (cfg_w == '0) ? WW'(1) :
                      (32'(cfg_w) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_w);

  // Current window column
  assign col_k  = (WW + 1)'(wrk_col_r) + (WW + 1)'(k_r);
  assign col_ok = (col_k >= (WW + 1)'(RADIUS)) && (col_k < (WW + 1)'(w_eff_r) + (WW + 1)'(RADIUS));
  assign col_x  = CW'(col_k - (WW + 1)'(RADIUS));

  assign lane_ctrl.clr    = start;
  assign lane_ctrl.rd     = (state_r == S_READ);
  assign lane_ctrl.col_ok = col_ok;

  // One lane per window row
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [HW:0]    row_y;
    logic           row_ok;
    logic [RGW+1:0] ring_v;
    logic [RGW-1:0] ring_l;

    assign row_y  = (HW + 1)'(wrk_row_r) + (HW + 1)'(l);
    assign row_ok = (row_y >= (HW + 1)'(RADIUS)) &&
                    (row_y < (HW + 1)'(h_eff_r) + (HW + 1)'(RADIUS));
    assign ring_v = (RGW + 2)'(wrk_ring_r) + (RGW + 2)'(RING - RADIUS + l);
    assign ring_l = (ring_v >= (RGW + 2)'(2 * RING)) ? RGW'(ring_v - (RGW + 2)'(2 * RING)) :
                    (ring_v >= (RGW + 2)'(RING))     ? RGW'(ring_v - (RGW + 2)'(RING)) :
                                                       RGW'(ring_v);

    bbc_lane #(
      .MAX_WIDTH (MAX_WIDTH),
      .RING      (RING)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (lane_ctrl),
      .row_ok  (row_ok),
      .ring    (ring_l),
      .col     (col_x),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .sum     (lane_sum[l])
    );
  end

  // Sum the lanes and divide by the clipped pixel count
  bbc_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_SUM),
    .lane_sum (lane_sum),
    .done     (mrg_done),
    .mean     (mrg_mean)
  );

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    w_eff_nxt     = w_eff_r;
    h_eff_nxt     = h_eff_r;
    in_col_nxt    = in_col_r;
    in_row_nxt    = in_row_r;
    in_ring_nxt   = in_ring_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_ring_nxt  = out_ring_r;
    rcv_nxt       = rcv_r;
    wrk_col_nxt   = wrk_col_r;
    wrk_row_nxt   = wrk_row_r;
    wrk_ring_nxt  = wrk_ring_r;
    wrk_last_nxt  = wrk_last_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_mean_nxt  = out_mean_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (wr_en) begin
          rcv_nxt = rcv_inc;
          if (in_wrap) begin
            in_col_nxt  = '0;
            in_row_nxt  = in_row_r + 1'b1;
            in_ring_nxt = (in_ring_r == RGW'(RING - 1)) ? '0 : in_ring_r + 1'b1;
          end else begin
            in_col_nxt = in_col_r + 1'b1;
          end
        end
        if (start) begin
          wrk_col_nxt  = out_col_r;
          wrk_row_nxt  = out_row_r;
          wrk_ring_nxt = out_ring_r;
          wrk_last_nxt = last;
          k_nxt        = '0;
          state_nxt    = S_READ;
          if (last) begin
            in_col_nxt   = '0;
            in_row_nxt   = '0;
            in_ring_nxt  = '0;
            out_col_nxt  = '0;
            out_row_nxt  = '0;
            out_ring_nxt = '0;
            rcv_nxt      = '0;
          end else if (out_wrap) begin
            out_col_nxt  = '0;
            out_row_nxt  = out_row_r + 1'b1;
            out_ring_nxt = (out_ring_r == RGW'(RING - 1)) ? '0 : out_ring_r + 1'b1;
          end else begin
            out_col_nxt = out_col_r + 1'b1;
          end
        end
      end
      S_READ: begin
        k_nxt = k_r + 1'b1;
        if (k_r == KW'(LANES - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_SUM;
      end
      S_SUM: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (mrg_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = mrg_mean;
          out_last_nxt  = wrk_last_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Register write aborts the frame
    if (cfg_wr_en) begin
      if (cfg_index == bbc_pkg::REG_WIDTH) begin
        w_eff_nxt = cfg_w_clip;
      end else begin
        h_eff_nxt = (cfg_h == '0) ? HW'(1) : cfg_h;
      end
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      in_ring_nxt  = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      out_ring_nxt = '0;
      rcv_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      w_eff_r     <= WW'(W_RST);
      h_eff_r     <= HW'(480);
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_ring_r   <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_ring_r  <= '0;
      rcv_r       <= '0;
      wrk_col_r   <= '0;
      wrk_row_r   <= '0;
      wrk_ring_r  <= '0;
      wrk_last_r  <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      out_mean_r  <= '0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_eff_r     <= w_eff_nxt;
      h_eff_r     <= h_eff_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      in_ring_r   <= in_ring_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      out_ring_r  <= out_ring_nxt;
      rcv_r       <= rcv_nxt;
      wrk_col_r   <= wrk_col_nxt;
      wrk_row_r   <= wrk_row_nxt;
      wrk_ring_r  <= wrk_ring_nxt;
      wrk_last_r  <= wrk_last_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      out_mean_r  <= out_mean_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_out    = out_mean_r[0];
  assign out_green_out  = out_mean_r[1];
  assign out_blue_out   = out_mean_r[2];
  assign out_frame_done = out_last_r;

  // Checks
  `BBC_ASSERT_NOW(a_row_bound, 1'b1, in_row_r <= h_eff_r)
  `BBC_ASSERT_NOW(a_done_in_div, mrg_done, state_r == S_DIV)
  `BBC_ASSERT_NEXT(a_start_reads, start, state_r == S_READ)
  `BBC_ASSERT_NOW(a_out_behind_in, state_r == S_IDLE && !in_full, out_row_r <= in_row_r)

endmodule

// ===== dv/tb_box_blur_5x5_clipped_core.sv =====
`timescale 1ns / 1ps
module tb_box_blur_5x5_clipped_core;

  localparam logic MODE_FLUSH = ~bbc_pkg::MODE_PIXEL;
  localparam int   MAX_W      = 1024;
  localparam int   RAD        = 2;
  localparam int   RING       = 3 * RAD + 1;
  localparam int   SETTLE     = 40;        // block latency with margin
  localparam int   CYCLE_LIMIT = 3000000;
  localparam int   RANDOM_ITEMS = 1450;

  typedef struct packed {
    logic [bbc_pkg::CH_W-1:0] red;
    logic [bbc_pkg::CH_W-1:0] green;
    logic [bbc_pkg::CH_W-1:0] blue;
    logic                     done;
  } blur_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic                       cfg_index;
  logic [bbc_pkg::CFG_DW-1:0] cfg_wdata;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_mode;
  logic [bbc_pkg::CH_W-1:0]   in_red_in;
  logic [bbc_pkg::CH_W-1:0]   in_green_in;
  logic [bbc_pkg::CH_W-1:0]   in_blue_in;
  logic                       out_valid;
  logic                       out_ready;
  logic [bbc_pkg::CH_W-1:0]   out_red_out;
  logic [bbc_pkg::CH_W-1:0]   out_green_out;
  logic [bbc_pkg::CH_W-1:0]   out_blue_out;
  logic                       out_frame_done;

  box_blur_5x5_clipped_core u_top (.*);

  // Predictor state: a shadow of the block's line stores and positions
  logic [bbc_pkg::PIX_W-1:0]  pix_ring [RING][MAX_W];
  logic [bbc_pkg::CFG_WW-1:0] shadow_width;
  logic [bbc_pkg::CFG_HW-1:0] shadow_height;
  int unsigned       rx_col, rx_row, tx_col, tx_row;
  bit                frame_closed;

  blur_result_t blur_q [$];
  int           fail_count;
  int           items_sent;
  int           send_gap_pct;
  int           recv_stall_pct;
  int           hold_request;
  int           hold_left;
  longint       cycle_count;

  // Clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** box_blur_5x5_clipped_core: FAILED **");
      $finish;
    end
  end

  function automatic int unsigned eff_w();
    if (shadow_width == 0) return 1;
    if (shadow_width > MAX_W) return MAX_W;
    return shadow_width;
  endfunction

  function automatic int unsigned eff_h();
    return (shadow_height == 0) ? 1 : shadow_height;
  endfunction

  // Window mean of the next pending output position, clipped to the image
  function automatic void emit_mean(int unsigned w, int unsigned h);
    int y0, y1, x0, x1, n;
    int unsigned sr, sg, sb;
    longint idx;
    logic [bbc_pkg::PIX_W-1:0] p;
    blur_result_t res;
    y0 = int'(tx_row) - RAD;
    y1 = int'(tx_row) + RAD;
    x0 = int'(tx_col) - RAD;
    x1 = int'(tx_col) + RAD;
    if (y0 < 0) y0 = 0;
    if (x0 < 0) x0 = 0;
    if (y1 > int'(h) - 1) y1 = int'(h) - 1;
    if (x1 > int'(w) - 1) x1 = int'(w) - 1;
    sr = 0;
    sg = 0;
    sb = 0;
    for (int y = y0; y <= y1; y++) begin
      for (int x = x0; x <= x1; x++) begin
        p = pix_ring[y % RING][x];
        sr += p[23:16];
        sg += p[15:8];
        sb += p[7:0];
      end
    end
    n = (y1 - y0 + 1) * (x1 - x0 + 1);
    idx = longint'(tx_row) * w + tx_col;
    res.red   = bbc_pkg::CH_W'(sr / n);
    res.green = bbc_pkg::CH_W'(sg / n);
    res.blue  = bbc_pkg::CH_W'(sb / n);
    res.done  = (idx + 1 == longint'(w) * h);
    blur_q.push_back(res);
    if (res.done) begin
      rx_col = 0;
      rx_row = 0;
      tx_col = 0;
      tx_row = 0;
      frame_closed = 1'b1;
    end else begin
      tx_col++;
      if (tx_col >= w) begin
        tx_col = 0;
        tx_row++;
      end
    end
  endfunction

  // Expected response to one accepted input transfer
  function automatic void predict_item(logic mode, logic [bbc_pkg::CH_W-1:0] r,
                                       logic [bbc_pkg::CH_W-1:0] g,
                                       logic [bbc_pkg::CH_W-1:0] b);
    int unsigned w, h;
    longint total, lag, received;
    w = eff_w();
    h = eff_h();
    total = longint'(w) * h;
    lag = longint'(RAD) * w + RAD;
    received = longint'(rx_row) * w + rx_col;
    if (mode == bbc_pkg::MODE_PIXEL) begin
      if (received >= total) return;
      pix_ring[rx_row % RING][rx_col] = {r, g, b};
      rx_col++;
      if (rx_col >= w) begin
        rx_col = 0;
        rx_row++;
      end
      if (received + 1 > lag) emit_mean(w, h);
    end else begin
      if (received < total) return;
      if (longint'(tx_row) * w + tx_col >= total) return;
      emit_mean(w, h);
    end
  endfunction

  // One input transfer; valid stays high afterwards unless the next call idles
  task automatic send_item(logic mode, logic [bbc_pkg::CH_W-1:0] r,
                           logic [bbc_pkg::CH_W-1:0] g, logic [bbc_pkg::CH_W-1:0] b);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    items_sent++;
    predict_item(mode, r, g, b);
  endtask

  task automatic send_pixel();
    send_item(bbc_pkg::MODE_PIXEL, bbc_pkg::CH_W'($urandom), bbc_pkg::CH_W'($urandom),
              bbc_pkg::CH_W'($urandom));
  endtask

  task automatic send_flush();
    send_item(MODE_FLUSH, bbc_pkg::CH_W'($urandom), bbc_pkg::CH_W'($urandom),
              bbc_pkg::CH_W'($urandom));
  endtask

  // Wait until every expected result is out and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blur_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One register write, then the write port is left quiet
  task automatic write_reg(logic idx, logic [bbc_pkg::CFG_DW-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == bbc_pkg::REG_WIDTH) shadow_width = value[bbc_pkg::CFG_WW-1:0];
    else shadow_height = value[bbc_pkg::CFG_HW-1:0];
    rx_col = 0;
    rx_row = 0;
    tx_col = 0;
    tx_row = 0;
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    write_reg(bbc_pkg::REG_WIDTH, bbc_pkg::CFG_DW'(w));
    write_reg(bbc_pkg::REG_HEIGHT, bbc_pkg::CFG_DW'(h));
  endtask

  // Full frame: pixels, then flushes until the last result; noise sprinkled in
  task automatic run_frame(int noise_pct);
    int unsigned total;
    total = eff_w() * eff_h();
    frame_closed = 1'b0;
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(99) < noise_pct) send_flush();
      send_pixel();
    end
    while (!frame_closed) begin
      if ($urandom_range(99) < noise_pct) send_pixel();
      else send_flush();
    end
    if ($urandom_range(99) < noise_pct) send_flush();
  endtask

  // Result checker: a transfer is committed when valid and ready are seen mid-cycle
  always @(negedge clk) begin
    blur_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (blur_q.size() == 0) begin
        $display("%0t: unexpected result %h %h %h done %b", $time, out_red_out,
                 out_green_out, out_blue_out, out_frame_done);
        fail_count++;
      end else begin
        want = blur_q.pop_front();
        if (want !== {out_red_out, out_green_out, out_blue_out, out_frame_done}) begin
          $display("%0t: mismatch expected r %h g %h b %h done %b, got r %h g %h b %h done %b",
                   $time, want.red, want.green, want.blue, want.done, out_red_out,
                   out_green_out, out_blue_out, out_frame_done);
          fail_count++;
        end
      end
    end
  end

  // Receiver side: random stalls, plus a long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Reset size: nothing comes out early, then a register write aborts the frame
  task automatic test_reset_size();
    for (int i = 0; i < 6; i++) send_pixel();
    drain();
    set_size(3, 2);
  endtask

  // 3x2 frame with early flush, extremes of the channels, extra pixel, idle flush
  task automatic test_small_frame();
    frame_closed = 1'b0;
    send_flush();
    send_item(bbc_pkg::MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(bbc_pkg::MODE_PIXEL, 8'h00, 8'h00, 8'h00);
    send_item(bbc_pkg::MODE_PIXEL, 8'hFF, 8'h00, 8'hAA);
    send_item(bbc_pkg::MODE_PIXEL, 8'h55, 8'hFF, 8'h00);
    send_item(bbc_pkg::MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(bbc_pkg::MODE_PIXEL, 8'hFE, 8'h01, 8'h80);
    send_pixel();
    while (!frame_closed) send_flush();
    send_flush();
    drain();
  endtask

  // Out-of-range sizes: width 0 and height 0 act as one pixel, oversize width clamps
  task automatic test_size_extremes();
    set_size(0, 0);
    run_frame(0);
    drain();
    set_size(2047, 65535);
    for (int i = 0; i < 8; i++) send_pixel();
    drain();
    set_size(1024, 1);
    for (int i = 0; i < 5; i++) send_pixel();
    drain();
    set_size(1, 7);
    run_frame(0);
    drain();
  endtask

  // Long receiver hold while the sender keeps offering a frame
  task automatic test_output_hold();
    set_size(6, 6);
    hold_request = 500;
    run_frame(0);
    drain();
  endtask

  // Random frames, mostly small, some aborted by a register write
  task automatic test_random_frames();
    int start;
    int unsigned w, h, cut;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      case (items_sent - start < RANDOM_ITEMS / 3 ? 0 :
            items_sent - start < 2 * RANDOM_ITEMS / 3 ? 1 : 2)
        0: begin
          send_gap_pct = 10;
          recv_stall_pct = 78;
        end
        1: begin
          send_gap_pct = 78;
          recv_stall_pct = 10;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      if ($urandom_range(9) == 0) w = $urandom_range(40, 10);
      else w = $urandom_range(9, 1);
      h = $urandom_range(8, 1);
      set_size(w, h);
      if ($urandom_range(19) == 0) begin
        cut = $urandom_range(w * h);
        for (int i = 0; i < cut; i++) send_pixel();
      end else begin
        run_frame(5);
      end
      drain();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= bbc_pkg::REG_WIDTH;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_mode        <= bbc_pkg::MODE_PIXEL;
    in_red_in      <= '0;
    in_green_in    <= '0;
    in_blue_in     <= '0;
    fail_count     = 0;
    items_sent     = 0;
    cycle_count    = 0;
    hold_request   = 0;
    hold_left      = 0;
    send_gap_pct   = 10;
    recv_stall_pct = 78;
    shadow_width   = 640;
    shadow_height  = 480;
    rx_col = 0;
    rx_row = 0;
    tx_col = 0;
    tx_row = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_size();
    test_small_frame();
    test_size_extremes();
    test_output_hold();
    test_random_frames();

    drain();
    if (fail_count == 0 && blur_q.size() == 0) begin
      $display("** box_blur_5x5_clipped_core: PASSED **");
    end else begin
      $display("** box_blur_5x5_clipped_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/bbc_pkg.sv
design/bbc_ram.sv
design/bbc_lane.sv
design/bbc_merge.sv
design/box_blur_5x5_clipped_core.sv
dv/tb_box_blur_5x5_clipped_core.sv
